### hw/rtl/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg: shared types and constants for the two-level page table manager
// Holds the transaction structs, operation/status codes and FSM states.
// ----------------------------------------------------------------------------
package tlpt_pkg;

	localparam int unsigned DIR_ENTRIES   = 1024;
	localparam int unsigned TABLE_ENTRIES = 1024;
	localparam int unsigned DIR_AW        = 10;
	localparam int unsigned PT_AW         = 20;
	localparam int unsigned ENTRY_W       = 21;   // present bit + page number
	localparam int unsigned PAGE_COUNT    = 1048576;

	typedef enum logic [2:0] {
		OP_TRANSLATE = 3'd0,
		OP_QUERY     = 3'd1,
		OP_MAP       = 3'd2,
		OP_UNMAP     = 3'd3,
		OP_FIND      = 3'd4
	} op_e;

	typedef enum logic [2:0] {
		STS_OK         = 3'd0,
		STS_RESERVED   = 3'd1,
		STS_NOT_PRESENT = 3'd2,
		STS_NO_TABLE   = 3'd3,
		STS_NONE_FOUND = 3'd4,
		STS_BAD_LENGTH = 3'd5
	} status_e;

	typedef enum logic {
		CFG_NULL_GUARD   = 1'b0,
		CFG_SEARCH_START = 1'b1
	} cfg_idx_e;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_EVAL,
		ST_FILL,
		ST_SCAN,
		ST_SREAD,
		ST_SEVAL,
		ST_DONE
	} state_e;

	typedef struct packed {
		logic [2:0]  operation;
		logic [19:0] virt_page;
		logic [11:0] page_offset;
		logic [19:0] phys_page;
		logic [19:0] table_page;
		logic        table_page_valid;
		logic [20:0] run_length;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] phys_address;
		logic        page_in_use;
		logic [19:0] found_base;
		logic        tlb_invalidate;
		logic        table_taken;
		logic        table_released;
		logic [19:0] released_table_page;
	} rsp_t;

endpackage

### hw/rtl/tlpt_ram.sv
// ----------------------------------------------------------------------------
// tlpt_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tlpt_ram #(
	parameter int unsigned WIDTH = 21,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/two_level_page_table_manager.sv
// ----------------------------------------------------------------------------
// two_level_page_table_manager: two-level 4 KiB paging store
// Directory and page tables live in two synchronous RAMs driven by one FSM.
// ----------------------------------------------------------------------------
// One transaction at a time. Translate and query go through ST_LOOKUP,
// ST_EVAL and ST_DONE. Map into a present table writes the entry in ST_EVAL;
// map into an empty directory slot also zeroes the new table through the
// page table write port. Unmap in a present table scans the table through
// the single read port, stopping early when a mapped entry turns up. The
// free-run search reads and evaluates one page at a time, directory and
// page table in parallel, with up to two walks from the search start, one
// towards each end of the 1048576-page range. The directory is cleared after
// reset, before the first transaction; config writes are taken throughout.
module two_level_page_table_manager (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tlpt_pkg::req_t      in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tlpt_pkg::rsp_t      out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [19:0]         cfg_data
);

	import tlpt_pkg::*;

	localparam logic [DIR_AW-1:0] DIR_LAST  = DIR_AW'(DIR_ENTRIES - 1);
	localparam logic [DIR_AW:0]   TBL_LIMIT = (DIR_AW + 1)'(TABLE_ENTRIES);
	localparam logic [PT_AW-1:0]  PAGE_MAX  = PT_AW'(PAGE_COUNT - 1);
	localparam logic [20:0]       LEN_MAX   = 21'(PAGE_COUNT);

	// registers
	state_e             state_q, state_d;
	req_t               req_q, req_d;
	rsp_t               res_q, res_d;
	rsp_t               out_q, out_d;
	logic               out_valid_q, out_valid_d;
	logic               guard_q;
	logic [19:0]        start_q;
	logic               down_q, down_d;
	logic [DIR_AW:0]    cnt_q, cnt_d;
	logic               chk_q, chk_d;
	logic [19:0]        tpage_q, tpage_d;
	logic [19:0]        pos_q, pos_d;
	logic [20:0]        run_q, run_d;
	logic [19:0]        base_q, base_d;
	logic               second_q, second_d;

	// memory ports
	logic                dir_we;
	logic [DIR_AW-1:0]   dir_waddr, dir_raddr;
	logic [ENTRY_W-1:0]  dir_wdata, dir_rdata;
	logic                pt_we;
	logic [PT_AW-1:0]    pt_waddr, pt_raddr;
	logic [ENTRY_W-1:0]  pt_wdata, pt_rdata;

	tlpt_ram #(.WIDTH(ENTRY_W), .DEPTH(DIR_ENTRIES)) u_dir_ram (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.raddr (dir_raddr),
		.rdata (dir_rdata)
	);

	tlpt_ram #(.WIDTH(ENTRY_W), .DEPTH(PAGE_COUNT)) u_pt_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	// decode of the latched request
	logic [DIR_AW-1:0] req_dir;
	logic [DIR_AW-1:0] req_tbl;
	logic              req_reserved;
	logic              req_guarded;
	logic              mapped;
	logic [DIR_AW-1:0] pos_dir;
	logic [DIR_AW-1:0] pos_tbl;
	logic              pos_used;
	logic [20:0]       run_inc;
	logic [19:0]       base_new;
	logic              at_end;
	logic              len_bad;

	assign req_dir      = req_q.virt_page[19:10];
	assign req_tbl      = req_q.virt_page[9:0];
	assign req_reserved = (req_dir >= DIR_LAST) || ({1'b0, req_tbl} >= TBL_LIMIT);
	assign req_guarded  = guard_q && (req_q.virt_page == '0);
	assign mapped       = dir_rdata[ENTRY_W-1] && pt_rdata[ENTRY_W-1];
	assign pos_dir      = pos_q[19:10];
	assign pos_tbl      = pos_q[9:0];
	assign pos_used     = (guard_q && pos_q == '0) || (pos_dir >= DIR_LAST)
	                      || ({1'b0, pos_tbl} >= TBL_LIMIT) || mapped;
	assign run_inc      = run_q + 21'd1;
	assign base_new     = (run_q == '0 || down_q) ? pos_q : base_q;
	assign at_end       = down_q ? (pos_q == '0) : (pos_q == PAGE_MAX);
	assign len_bad      = (in_data.run_length == '0) || (in_data.run_length > LEN_MAX);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q <= 1'b0;
			start_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_e'(cfg_index))
				CFG_NULL_GUARD:   guard_q <= cfg_data[0];
				CFG_SEARCH_START: start_q <= cfg_data;
				default:          guard_q <= guard_q;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
			down_q      <= 1'b0;
			cnt_q       <= '0;
			chk_q       <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			down_q      <= down_d;
			cnt_q       <= cnt_d;
			chk_q       <= chk_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		req_q    <= req_d;
		res_q    <= res_d;
		out_q    <= out_d;
		tpage_q  <= tpage_d;
		pos_q    <= pos_d;
		run_q    <= run_d;
		base_q   <= base_d;
		second_q <= second_d;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// next state, memory control and result build-up
	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		res_d       = res_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && !out_ready;
		down_d      = down_q;
		cnt_d       = cnt_q;
		chk_d       = chk_q;
		tpage_d     = tpage_q;
		pos_d       = pos_q;
		run_d       = run_q;
		base_d      = base_q;
		second_d    = second_q;

		dir_we    = 1'b0;
		dir_waddr = req_dir;
		dir_wdata = '0;
		dir_raddr = req_dir;
		pt_we     = 1'b0;
		pt_waddr  = req_q.virt_page;
		pt_wdata  = '0;
		pt_raddr  = req_q.virt_page;

		case (state_q)
			// directory sweep after reset
			ST_CLEAR: begin
				dir_we    = 1'b1;
				dir_waddr = cnt_q[DIR_AW-1:0];
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q[DIR_AW-1:0] == DIR_LAST) begin
					state_d = ST_IDLE;
				end
			end

			ST_IDLE: begin
				if (in_valid) begin
					req_d = in_data;
					res_d = '0;
					cnt_d = '0;
					chk_d = 1'b0;
					case (op_e'(in_data.operation))
						OP_TRANSLATE, OP_QUERY, OP_MAP, OP_UNMAP: begin
							state_d = ST_LOOKUP;
						end
						OP_FIND: begin
							if (len_bad) begin
								res_d.status = STS_BAD_LENGTH;
								state_d      = ST_DONE;
							end else begin
								pos_d    = start_q;
								run_d    = '0;
								base_d   = '0;
								second_d = 1'b0;
								state_d  = ST_SREAD;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end

			// read directory slot and page entry together
			ST_LOOKUP: begin
				state_d = ST_EVAL;
			end

			ST_EVAL: begin
				state_d = ST_DONE;
				tpage_d = dir_rdata[19:0];
				case (op_e'(req_q.operation))
					OP_TRANSLATE: begin
						if (req_reserved) begin
							res_d.status = STS_RESERVED;
						end else if (!mapped) begin
							res_d.status = STS_NOT_PRESENT;
						end else begin
							res_d.phys_address = {pt_rdata[19:0], req_q.page_offset};
						end
					end
					OP_QUERY: begin
						if (req_reserved) begin
							res_d.status = STS_RESERVED;
						end
						res_d.page_in_use = req_reserved || req_guarded || mapped;
					end
					OP_MAP: begin
						if (req_reserved || req_guarded) begin
							res_d.status = STS_RESERVED;
						end else if (!dir_rdata[ENTRY_W-1]) begin
							if (!req_q.table_page_valid) begin
								res_d.status = STS_NO_TABLE;
							end else begin
								dir_we               = 1'b1;
								dir_wdata            = {1'b1, req_q.table_page};
								res_d.table_taken    = 1'b1;
								res_d.tlb_invalidate = 1'b1;
								cnt_d                = '0;
								state_d              = ST_FILL;
							end
						end else begin
							pt_we                = 1'b1;
							pt_wdata             = {1'b1, req_q.phys_page};
							res_d.tlb_invalidate = 1'b1;
						end
					end
					OP_UNMAP: begin
						if (req_reserved) begin
							res_d.status = STS_RESERVED;
						end else if (!dir_rdata[ENTRY_W-1]) begin
							res_d.status = STS_NOT_PRESENT;
						end else begin
							pt_we                = 1'b1;
							res_d.tlb_invalidate = 1'b1;
							cnt_d                = '0;
							chk_d                = 1'b0;
							state_d              = ST_SCAN;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end

			// zero the new table, installing the mapped entry on the way
			ST_FILL: begin
				pt_we    = 1'b1;
				pt_waddr = {req_dir, cnt_q[DIR_AW-1:0]};
				pt_wdata = (cnt_q[DIR_AW-1:0] == req_tbl) ? {1'b1, req_q.phys_page} : '0;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q[DIR_AW-1:0] == DIR_AW'(TABLE_ENTRIES - 1)) begin
					state_d = ST_DONE;
				end
			end

			// look for any present entry; none left means the table is freed
			ST_SCAN: begin
				pt_raddr = {req_dir, cnt_q[DIR_AW-1:0]};
				if (chk_q && pt_rdata[ENTRY_W-1]) begin
					state_d = ST_DONE;
				end else if (cnt_q == TBL_LIMIT) begin
					dir_we                    = 1'b1;
					res_d.table_released      = 1'b1;
					res_d.released_table_page = tpage_q;
					state_d                   = ST_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
					chk_d = 1'b1;
				end
			end

			// free-run search: one page per read/evaluate pair
			ST_SREAD: begin
				dir_raddr = pos_dir;
				pt_raddr  = pos_q;
				state_d   = ST_SEVAL;
			end

			ST_SEVAL: begin
				state_d = ST_SREAD;
				if (!pos_used && run_inc == req_q.run_length) begin
					res_d.found_base = base_new;
					state_d          = ST_DONE;
				end else begin
					if (!pos_used) begin
						run_d  = run_inc;
						base_d = base_new;
					end else begin
						run_d  = '0;
						base_d = '0;
					end
					if (at_end) begin
						if (second_q) begin
							res_d.status = STS_NONE_FOUND;
							state_d      = ST_DONE;
						end else begin
							down_d   = !down_q;
							pos_d    = start_q;
							run_d    = '0;
							base_d   = '0;
							second_d = 1'b1;
						end
					end else begin
						pos_d = down_q ? pos_q - 20'd1 : pos_q + 20'd1;
					end
				end
			end

			// hand the result to the output register once it is free
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_d       = res_q;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

endmodule
